FILE: rtl/ertm_pkg.sv
// ----------------------------------------------------------------------------
// ertm_pkg
// Shared types, request codes and conversion tables for the extended-range
// one-shot and periodic timer.
// ----------------------------------------------------------------------------
`default_nettype none

package ertm_pkg;

    localparam int unsigned E_CLOCK_HZ    = 8000000;
    localparam int unsigned DECIMAL_STEPS = 6;

    localparam logic [31:0] DIV10_RECIP   = 32'hCCCCCCCD;
    localparam logic [31:0] DIV1000_RECIP = 32'd2199023256;

    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_ONESHOT  = 2'd1,
        REQ_PERIODIC = 2'd2,
        REQ_READ     = 2'd3
    } ertm_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE_US,
        ST_SCALE_PROD,
        ST_APPLY,
        ST_TIME,
        ST_EMIT
    } ertm_state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] delay_us;
    } ertm_in_t;

    typedef struct packed {
        logic        once_fired;
        logic        periodic_fired;
        logic [31:0] cycle_count;
        logic [31:0] micro_time;
        logic [22:0] milli_time;
    } ertm_out_t;

    typedef struct packed {
        logic load;
        logic div;
        logic mul;
        logic apply;
        logic time_calc;
        logic emit;
    } ertm_cmd_t;

    typedef struct packed {
        logic      steps_zero;
        logic      over_limit;
        logic      out_full;
        ertm_req_t req;
    } ertm_stat_t;

    function automatic logic [31:0] reduced_freq(input int unsigned p);
        int unsigned f;
        f = E_CLOCK_HZ >> p;
        if (f == 0) begin
            f = 1;
        end
        for (int i = 0; i < DECIMAL_STEPS; i++) begin
            if (f % 10 == 0) begin
                f = f / 10;
            end
        end
        return 32'(f);
    endfunction

    function automatic logic [2:0] left_steps(input int unsigned p);
        int unsigned f;
        int unsigned s;
        f = E_CLOCK_HZ >> p;
        s = DECIMAL_STEPS;
        if (f == 0) begin
            f = 1;
        end
        for (int i = 0; i < DECIMAL_STEPS; i++) begin
            if (s > 0 && f % 10 == 0) begin
                f = f / 10;
                s = s - 1;
            end
        end
        return 3'(s);
    endfunction

    localparam logic [31:0] F_TAB [8] = '{
        reduced_freq(0), reduced_freq(1), reduced_freq(2), reduced_freq(3),
        reduced_freq(4), reduced_freq(5), reduced_freq(6), reduced_freq(7)
    };

    localparam logic [2:0] STEPS_TAB [8] = '{
        left_steps(0), left_steps(1), left_steps(2), left_steps(3),
        left_steps(4), left_steps(5), left_steps(6), left_steps(7)
    };

    localparam logic [31:0] LIMIT_TAB [8] = '{
        32'hFFFFFFFF / F_TAB[0], 32'hFFFFFFFF / F_TAB[1],
        32'hFFFFFFFF / F_TAB[2], 32'hFFFFFFFF / F_TAB[3],
        32'hFFFFFFFF / F_TAB[4], 32'hFFFFFFFF / F_TAB[5],
        32'hFFFFFFFF / F_TAB[6], 32'hFFFFFFFF / F_TAB[7]
    };

endpackage

`default_nettype wire

FILE: rtl/ertm_ctrl.sv
// ----------------------------------------------------------------------------
// ertm_ctrl
// Sequencer: accepts a request, steps the microsecond conversion, applies
// the request and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ertm_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                m_ready,
    input  wire ertm_pkg::ertm_stat_t stat,
    output ertm_pkg::ertm_cmd_t      cmd
);

    ertm_pkg::ertm_state_t state_reg;
    ertm_pkg::ertm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ertm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ertm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ertm_pkg::ST_SCALE_US;
                end
            end
            ertm_pkg::ST_SCALE_US: begin
                if (!(stat.req inside {ertm_pkg::REQ_ONESHOT, ertm_pkg::REQ_PERIODIC})) begin
                    state_next = ertm_pkg::ST_APPLY;
                end else if (!stat.steps_zero && stat.over_limit) begin
                    cmd.div = 1'b1;
                end else begin
                    cmd.mul    = 1'b1;
                    state_next = ertm_pkg::ST_SCALE_PROD;
                end
            end
            ertm_pkg::ST_SCALE_PROD: begin
                if (!stat.steps_zero) begin
                    cmd.div = 1'b1;
                end else begin
                    state_next = ertm_pkg::ST_APPLY;
                end
            end
            ertm_pkg::ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = ertm_pkg::ST_TIME;
            end
            ertm_pkg::ST_TIME: begin
                cmd.time_calc = 1'b1;
                state_next    = ertm_pkg::ST_EMIT;
            end
            ertm_pkg::ST_EMIT: begin
                if (!stat.out_full || m_ready) begin
                    cmd.emit   = 1'b1;
                    state_next = ertm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ertm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/ertm_dp.sv
// ----------------------------------------------------------------------------
// ertm_dp
// Datapath: timer state, microsecond conversion unit, time scaling and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ertm_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [2:0]          cfg_wr_data,
    input  wire ertm_pkg::ertm_in_t  s_data,
    input  wire logic                m_ready,
    output logic                     m_valid,
    output ertm_pkg::ertm_out_t      m_data,
    input  wire ertm_pkg::ertm_cmd_t cmd,
    output ertm_pkg::ertm_stat_t     stat
);

    logic [2:0]  prescale_reg;
    ertm_pkg::ertm_req_t req_reg;
    logic [31:0] work_reg;
    logic [2:0]  steps_reg;
    logic [15:0] tick_reg, wrap_reg;
    logic [15:0] once_cmp_reg, once_pend_reg;
    logic        once_armed_reg;
    logic [15:0] per_cmp_reg, per_pend_reg, per_reload_reg, per_low_reg;
    logic        per_armed_reg;
    logic        of_reg, pf_reg;
    logic [31:0] micro_reg;
    logic        m_valid_reg;
    ertm_pkg::ertm_out_t out_reg;

    logic [63:0] div10_prod;
    logic [31:0] div10_q;
    logic [31:0] mul_q;
    logic [15:0] tick_next;
    logic [15:0] wraps, low;
    logic        once_hit, per_hit;
    logic [31:0] cyc;
    logic [31:0] micro_next;
    logic [63:0] milli_prod;

    assign div10_prod = 64'(work_reg) * 64'(ertm_pkg::DIV10_RECIP);
    assign div10_q    = 32'(div10_prod[63:35]);
    assign mul_q      = work_reg * ertm_pkg::F_TAB[prescale_reg];
    assign tick_next  = tick_reg + 16'd1;
    assign wraps      = work_reg[31:16];
    assign low        = (work_reg == 32'd0) ? 16'd1 : work_reg[15:0];
    assign once_hit   = once_armed_reg && (tick_next == once_cmp_reg);
    assign per_hit    = per_armed_reg && (tick_next == per_cmp_reg);
    assign cyc        = {wrap_reg, tick_reg};
    assign micro_next = (prescale_reg >= 3'd3) ? (cyc << (prescale_reg - 3'd3))
                                               : (cyc >> (3'd3 - prescale_reg));
    assign milli_prod = 64'(micro_reg) * 64'(ertm_pkg::DIV1000_RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg   <= '0;
            tick_reg       <= '0;
            wrap_reg       <= '0;
            once_cmp_reg   <= '0;
            once_pend_reg  <= '0;
            once_armed_reg <= 1'b0;
            per_cmp_reg    <= '0;
            per_pend_reg   <= '0;
            per_reload_reg <= '0;
            per_low_reg    <= '0;
            per_armed_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                prescale_reg <= cfg_wr_data;
            end
            if (cmd.apply) begin
                case (req_reg)
                    ertm_pkg::REQ_TICK: begin
                        tick_reg <= tick_next;
                        if (tick_next == 16'd0) begin
                            wrap_reg <= wrap_reg + 16'd1;
                        end
                        if (once_hit) begin
                            if (once_pend_reg != 16'd0) begin
                                once_pend_reg <= once_pend_reg - 16'd1;
                            end else begin
                                once_armed_reg <= 1'b0;
                            end
                        end
                        if (per_hit) begin
                            if (per_pend_reg != 16'd0) begin
                                per_pend_reg <= per_pend_reg - 16'd1;
                            end else begin
                                per_pend_reg <= per_reload_reg;
                                per_cmp_reg  <= tick_next + per_low_reg;
                            end
                        end
                    end
                    ertm_pkg::REQ_ONESHOT: begin
                        once_pend_reg  <= wraps;
                        once_cmp_reg   <= tick_reg + low;
                        once_armed_reg <= 1'b1;
                    end
                    ertm_pkg::REQ_PERIODIC: begin
                        per_pend_reg   <= wraps;
                        per_reload_reg <= wraps;
                        per_low_reg    <= low;
                        per_cmp_reg    <= tick_reg + low;
                        per_armed_reg  <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= ertm_pkg::ertm_req_t'(s_data.req_type);
            work_reg  <= s_data.delay_us;
            steps_reg <= ertm_pkg::STEPS_TAB[prescale_reg];
        end else if (cmd.div) begin
            work_reg  <= div10_q;
            steps_reg <= steps_reg - 3'd1;
        end else if (cmd.mul) begin
            work_reg <= mul_q;
        end
        if (cmd.apply) begin
            of_reg <= (req_reg == ertm_pkg::REQ_TICK) && once_hit
                      && (once_pend_reg == 16'd0);
            pf_reg <= (req_reg == ertm_pkg::REQ_TICK) && per_hit
                      && (per_pend_reg == 16'd0);
        end
        if (cmd.time_calc) begin
            micro_reg <= micro_next;
        end
        if (cmd.emit) begin
            out_reg.once_fired     <= of_reg;
            out_reg.periodic_fired <= pf_reg;
            out_reg.cycle_count    <= cyc;
            out_reg.micro_time     <= micro_reg;
            out_reg.milli_time     <= milli_prod[63:41];
        end
    end

    assign stat.steps_zero = (steps_reg == 3'd0);
    assign stat.over_limit = (work_reg > ertm_pkg::LIMIT_TAB[prescale_reg]);
    assign stat.out_full   = m_valid_reg;
    assign stat.req        = req_reg;
    assign m_valid         = m_valid_reg;
    assign m_data          = out_reg;

    a_div_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div |-> steps_reg != 3'd0)
        else $error("decimal step taken with none left");

    a_once_disarm: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply && req_reg == ertm_pkg::REQ_TICK && once_hit
        && once_pend_reg == 16'd0 |=> !once_armed_reg && of_reg)
        else $error("one-shot fired without disarming");

    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !m_valid_reg || m_ready)
        else $error("result overwrote a pending result");

endmodule

`default_nettype wire

FILE: rtl/extended_range_oneshot_periodic_timer_top.sv
// ----------------------------------------------------------------------------
// extended_range_oneshot_periodic_timer_top
// Output-compare timer with a 16-bit counter, a 16-bit wrap extension and
// a one-shot and a periodic compare channel.
//
// Usage:
//   s_valid/s_ready/s_data carry one request: tick, arm one-shot, arm
//   periodic or read time. Every request gives one result on
//   m_valid/m_ready/m_data with the fire flags and the current time.
//   cfg_wr_en/cfg_wr_data write the 3-bit prescale; write it only idle.
// Sequencing:
//   tick and read requests pass the scale, apply, time and emit states;
//   arm requests add one multiply and N decimal divide-by-ten steps,
//   N being the steps left (at most 4), one per cycle in the shared
//   reciprocal unit. One request is in flight at a time.
// Reset:
//   aresetn (synchronous, active low) clears the counters, disarms both
//   channels, sets prescale to zero and drops any pending result.
// Stall:
//   a result holds in the output register while m_ready is low; the
//   sequencer waits before emitting the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module extended_range_oneshot_periodic_timer_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [2:0]          cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ertm_pkg::ertm_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ertm_pkg::ertm_out_t      m_data
);

    ertm_pkg::ertm_cmd_t  cmd;
    ertm_pkg::ertm_stat_t stat;

    ertm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ertm_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire
